// File: rtl/rdc_pkg.sv
// Package: widths, command codes and transfer structs for the resize debounce coalescer.
package rdc_pkg;

    localparam int SIZE_BITS = 16;
    localparam int TIME_BITS = 48;
    localparam int WIN_BITS  = 16;
    localparam int CMD_BITS  = 3;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = WIN_BITS'(100);
    localparam logic [WIN_BITS-1:0] WINDOW_MIN   = WIN_BITS'(1);

    localparam logic [CMD_BITS-1:0] CMD_SIZE_REQ  = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_RATIO_REQ = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_TIMER     = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR     = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_SET_SIZE  = 3'd4;

    typedef struct packed {
        logic [CMD_BITS-1:0]  command;
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
        logic [TIME_BITS-1:0] now_ms;
    } rdc_item_t;

    typedef struct packed {
        logic                 apply_valid;
        logic [SIZE_BITS-1:0] apply_width;
        logic [SIZE_BITS-1:0] apply_height;
        logic                 wakeup_valid;
        logic [WIN_BITS-1:0]  wakeup_after_ms;
    } rdc_result_t;

endpackage

// File: rtl/rdc_core.sv
// Debounce state registers and the single-pass next-state and result logic.
module rdc_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  rdc_pkg::rdc_item_t          item,
    input  logic [rdc_pkg::WIN_BITS-1:0] window,
    output rdc_pkg::rdc_result_t        result
);
    import rdc_pkg::*;

    logic                 pend_present_reg, pend_present_next;
    logic [SIZE_BITS-1:0] pend_w_reg, pend_w_next;
    logic [SIZE_BITS-1:0] pend_h_reg, pend_h_next;
    logic                 rel_present_reg, rel_present_next;
    logic [SIZE_BITS-1:0] rel_w_reg, rel_w_next;
    logic [SIZE_BITS-1:0] rel_h_reg, rel_h_next;
    logic [TIME_BITS-1:0] last_time_reg, last_time_next;

    logic                 eq_rel;
    logic [TIME_BITS:0]   diff;
    logic                 backwards;
    logic                 not_due;
    logic [WIN_BITS-1:0]  remaining;

    always_comb begin
        eq_rel    = rel_present_reg && (rel_w_reg == item.width) && (rel_h_reg == item.height);
        diff      = {1'b0, item.now_ms} - {1'b0, last_time_reg};
        backwards = diff[TIME_BITS];
        // not due when time went backwards, or elapsed fits in the window width and is smaller
        not_due   = backwards
                 || (((diff[TIME_BITS-1:0] >> WIN_BITS) == '0)
                     && (diff[WIN_BITS-1:0] < window));
        remaining = backwards ? window : (window - diff[WIN_BITS-1:0]);
    end

    always_comb begin
        pend_present_next = pend_present_reg;
        pend_w_next       = pend_w_reg;
        pend_h_next       = pend_h_reg;
        rel_present_next  = rel_present_reg;
        rel_w_next        = rel_w_reg;
        rel_h_next        = rel_h_reg;
        last_time_next    = last_time_reg;
        result            = '0;
        case (item.command)
            CMD_SIZE_REQ: begin
                if (eq_rel) begin
                    pend_present_next = 1'b0;
                end else begin
                    pend_present_next      = 1'b1;
                    pend_w_next            = item.width;
                    pend_h_next            = item.height;
                    last_time_next         = item.now_ms;
                    result.wakeup_valid    = 1'b1;
                    result.wakeup_after_ms = window;
                end
            end
            CMD_RATIO_REQ: begin
                pend_present_next = 1'b0;
                if (!eq_rel) begin
                    rel_present_next    = 1'b1;
                    rel_w_next          = item.width;
                    rel_h_next          = item.height;
                    result.apply_valid  = 1'b1;
                    result.apply_width  = item.width;
                    result.apply_height = item.height;
                end
            end
            CMD_TIMER: begin
                if (pend_present_reg) begin
                    if (not_due) begin
                        result.wakeup_valid    = 1'b1;
                        result.wakeup_after_ms = remaining;
                    end else begin
                        pend_present_next   = 1'b0;
                        rel_present_next    = 1'b1;
                        rel_w_next          = pend_w_reg;
                        rel_h_next          = pend_h_reg;
                        result.apply_valid  = 1'b1;
                        result.apply_width  = pend_w_reg;
                        result.apply_height = pend_h_reg;
                    end
                end
            end
            CMD_CLEAR: begin
                pend_present_next = 1'b0;
                rel_present_next  = 1'b0;
                last_time_next    = '0;
            end
            CMD_SET_SIZE: begin
                pend_present_next = 1'b0;
                rel_present_next  = 1'b1;
                rel_w_next        = item.width;
                rel_h_next        = item.height;
                last_time_next    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_present_reg <= 1'b0;
            pend_w_reg       <= '0;
            pend_h_reg       <= '0;
            rel_present_reg  <= 1'b0;
            rel_w_reg        <= '0;
            rel_h_reg        <= '0;
            last_time_reg    <= '0;
        end else if (fire) begin
            pend_present_reg <= pend_present_next;
            pend_w_reg       <= pend_w_next;
            pend_h_reg       <= pend_h_next;
            rel_present_reg  <= rel_present_next;
            rel_w_reg        <= rel_w_next;
            rel_h_reg        <= rel_h_next;
            last_time_reg    <= last_time_next;
        end
    end

endmodule

// File: rtl/rdc_out_reg.sv
// Result register with its valid flag and the stage advance control.
module rdc_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  rdc_pkg::rdc_result_t result,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic                 advance,
    output rdc_pkg::rdc_result_t held
);
    import rdc_pkg::*;

    logic        valid_reg, valid_next;
    rdc_result_t data_reg;

    always_comb begin
        // advance when the slot is empty or is drained this cycle
        advance    = !valid_reg || m_ready;
        valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign held    = data_reg;

endmodule

// File: rtl/resize_event_debounce_coalescer.sv
// Top level: input register, window register, debounce core and result register.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------
//  s_       | s_valid / s_ready  | command, width, height, now_ms
//  m_       | m_valid / m_ready  | apply_valid/width/height, wakeup_valid/after_ms
//  cfg_     | cfg_we             | cfg_wdata: debounce window in ms
//
// One transfer per cycle while m_ready is high; a result passes from its input transfer
// through the input register, then the single-pass core, into the result register.
// A stalled m_ready holds the result register and backs up into the input register.
// aresetn is synchronous, active low; the window resets to 100 ms, a written 0 acts as 1.
module resize_event_debounce_coalescer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rdc_pkg::CMD_BITS-1:0]  s_command,
    input  logic [rdc_pkg::SIZE_BITS-1:0] s_width,
    input  logic [rdc_pkg::SIZE_BITS-1:0] s_height,
    input  logic [rdc_pkg::TIME_BITS-1:0] s_now_ms,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_apply_valid,
    output logic [rdc_pkg::SIZE_BITS-1:0] m_apply_width,
    output logic [rdc_pkg::SIZE_BITS-1:0] m_apply_height,
    output logic                          m_wakeup_valid,
    output logic [rdc_pkg::WIN_BITS-1:0]  m_wakeup_after_ms,
    input  logic                          cfg_we,
    input  logic [rdc_pkg::WIN_BITS-1:0]  cfg_wdata
);
    import rdc_pkg::*;

    logic                in_valid_reg, in_valid_next;
    rdc_item_t           in_item_reg;
    logic [WIN_BITS-1:0] window_reg, window_next;
    logic                advance;
    logic                fire;
    rdc_result_t         core_result;
    rdc_result_t         held;

    always_comb begin
        fire          = in_valid_reg && advance;
        s_ready       = !in_valid_reg || advance;
        in_valid_next = (s_valid && s_ready) ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        window_next   = (cfg_wdata == '0) ? WINDOW_MIN : cfg_wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            window_reg   <= WINDOW_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{command: s_command, width: s_width,
                             height: s_height, now_ms: s_now_ms};
        end
    end

    rdc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .window  (window_reg),
        .result  (core_result)
    );

    rdc_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (fire),
        .result  (core_result),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .advance (advance),
        .held    (held)
    );

    assign m_apply_valid     = held.apply_valid;
    assign m_apply_width     = held.apply_width;
    assign m_apply_height    = held.apply_height;
    assign m_wakeup_valid    = held.wakeup_valid;
    assign m_wakeup_after_ms = held.wakeup_after_ms;

endmodule
